[src/pit_pkg.sv]
// shared constants and index tables for the point-in-triangle test
package pit_pkg;

	// default coordinate width
	localparam int unsigned COORD_WIDTH_DEF = 16;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERTEX_A = 2'd0,
		REG_VERTEX_B = 2'd1,
		REG_VERTEX_C = 2'd2
	} reg_idx_t;

	// vector and axis counts
	localparam int unsigned NUM_AXES = 3;
	localparam int unsigned NUM_VEC  = 3;
	localparam int unsigned NUM_DOT  = 5;
	localparam int unsigned NUM_PROD = 6;

	// difference vectors: e0 = c - a, e1 = b - a, w = p - a
	localparam int unsigned VEC_E0 = 0;
	localparam int unsigned VEC_E1 = 1;
	localparam int unsigned VEC_W  = 2;

	// dot products
	localparam int unsigned DOT_00 = 0;
	localparam int unsigned DOT_01 = 1;
	localparam int unsigned DOT_02 = 2;
	localparam int unsigned DOT_11 = 3;
	localparam int unsigned DOT_12 = 4;

	localparam int unsigned DOT_VEC_A [NUM_DOT] = '{VEC_E0, VEC_E0, VEC_E0, VEC_E1, VEC_E1};
	localparam int unsigned DOT_VEC_B [NUM_DOT] = '{VEC_E0, VEC_E1, VEC_W, VEC_E1, VEC_W};

	// wide products, in pairs: positive term then subtracted term
	localparam int unsigned PROD_DET_P = 0;
	localparam int unsigned PROD_DET_N = 1;
	localparam int unsigned PROD_UN_P  = 2;
	localparam int unsigned PROD_UN_N  = 3;
	localparam int unsigned PROD_VN_P  = 4;
	localparam int unsigned PROD_VN_N  = 5;

	localparam int unsigned PROD_DOT_A [NUM_PROD] = '{DOT_00, DOT_01, DOT_11, DOT_01, DOT_00, DOT_01};
	localparam int unsigned PROD_DOT_B [NUM_PROD] = '{DOT_11, DOT_01, DOT_02, DOT_12, DOT_12, DOT_02};

	// result item layout
	localparam int unsigned OUT_TDATA_W    = 8;
	localparam int unsigned OUT_BIT_INSIDE = 0;
	localparam int unsigned OUT_BIT_DEGEN  = 1;

endpackage

[src/pit_dot.sv]
// stages 1 to 3: difference vectors, per-axis products and the five dot products
module pit_dot import pit_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [3*COORD_WIDTH-1:0]               vertex_a,
	input  logic [3*COORD_WIDTH-1:0]               vertex_b,
	input  logic [3*COORD_WIDTH-1:0]               vertex_c,
	input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   point,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [NUM_DOT-1:0][2*COORD_WIDTH+3:0]  dot
);

	localparam int unsigned W      = COORD_WIDTH;
	localparam int unsigned DIFF_W = W + 1;
	localparam int unsigned PR_W   = 2 * DIFF_W;
	localparam int unsigned DOT_W  = PR_W + 2;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic [NUM_VEC-1:0][NUM_AXES-1:0][DIFF_W-1:0] vec_d, vec_s1;
	logic [NUM_DOT-1:0][NUM_AXES-1:0][PR_W-1:0]   pr_d, pr_s2;
	logic [NUM_DOT-1:0][DOT_W-1:0]                dot_d, dot_s3;

	// stage handshake: a stage loads when empty or when its successor takes its item
	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign out_valid = v_s3;
	assign dot       = dot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: difference vectors relative to vertex a
	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			vec_d[VEC_E0][k] = {vertex_c[k*W+W-1], vertex_c[k*W +: W]}
				- {vertex_a[k*W+W-1], vertex_a[k*W +: W]};
			vec_d[VEC_E1][k] = {vertex_b[k*W+W-1], vertex_b[k*W +: W]}
				- {vertex_a[k*W+W-1], vertex_a[k*W +: W]};
			vec_d[VEC_W][k]  = {point[k][W-1], point[k]}
				- {vertex_a[k*W+W-1], vertex_a[k*W +: W]};
		end
	end

	// stage 2: one signed product per dot product and axis
	for (genvar d = 0; d < NUM_DOT; d++) begin : g_dot
		for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
			logic [DIFF_W-1:0] op_a, op_b;
			assign op_a = vec_s1[DOT_VEC_A[d]][k];
			assign op_b = vec_s1[DOT_VEC_B[d]][k];
			assign pr_d[d][k] = {{DIFF_W{op_a[DIFF_W-1]}}, op_a}
				* {{DIFF_W{op_b[DIFF_W-1]}}, op_b};
		end
		// stage 3: sum over the three axes
		assign dot_d[d] = {{2{pr_s2[d][0][PR_W-1]}}, pr_s2[d][0]}
			+ {{2{pr_s2[d][1][PR_W-1]}}, pr_s2[d][1]}
			+ {{2{pr_s2[d][2][PR_W-1]}}, pr_s2[d][2]};
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) vec_s1 <= vec_d;
		if (rdy_s2 && v_s1) pr_s2 <= pr_d;
		if (rdy_s3 && v_s2) dot_s3 <= dot_d;
	end

endmodule

[src/pit_mul.sv]
// stages 4 and 5: six wide dot-by-dot products split into four partial products each
module pit_mul import pit_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [NUM_DOT-1:0][2*COORD_WIDTH+3:0]  dot,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [NUM_PROD-1:0][4*COORD_WIDTH+7:0] prod
);

	localparam int unsigned DOT_W  = 2 * COORD_WIDTH + 4;
	localparam int unsigned LO_W   = DOT_W / 2;
	localparam int unsigned HI_W   = DOT_W - LO_W;
	localparam int unsigned PROD_W = 2 * DOT_W;
	localparam int unsigned HH_W   = 2 * HI_W;
	localparam int unsigned HL_W   = HI_W + LO_W + 1;
	localparam int unsigned LL_W   = 2 * LO_W;

	logic v_s4, v_s5;
	logic rdy_s4, rdy_s5;

	logic [NUM_PROD-1:0][HH_W-1:0]   hh_d, hh_s4;
	logic [NUM_PROD-1:0][HL_W-1:0]   hl_d, hl_s4, lh_d, lh_s4;
	logic [NUM_PROD-1:0][LL_W-1:0]   ll_d, ll_s4;
	logic [NUM_PROD-1:0][PROD_W-1:0] prod_d, prod_s5;

	assign rdy_s5    = !v_s5 || out_ready;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign in_ready  = rdy_s4;
	assign out_valid = v_s5;
	assign prod      = prod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= in_valid;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	for (genvar g = 0; g < NUM_PROD; g++) begin : g_prod
		logic [DOT_W-1:0] a, b;
		logic [HI_W-1:0]  a_hi, b_hi;
		logic [LO_W-1:0]  a_lo, b_lo;

		assign a    = dot[PROD_DOT_A[g]];
		assign b    = dot[PROD_DOT_B[g]];
		assign a_hi = a[DOT_W-1:LO_W];
		assign b_hi = b[DOT_W-1:LO_W];
		assign a_lo = a[LO_W-1:0];
		assign b_lo = b[LO_W-1:0];

		// stage 4: signed high halves, unsigned low halves
		assign hh_d[g] = {{(HH_W-HI_W){a_hi[HI_W-1]}}, a_hi}
			* {{(HH_W-HI_W){b_hi[HI_W-1]}}, b_hi};
		assign hl_d[g] = {{(HL_W-HI_W){a_hi[HI_W-1]}}, a_hi}
			* {{(HL_W-LO_W){1'b0}}, b_lo};
		assign lh_d[g] = {{(HL_W-LO_W){1'b0}}, a_lo}
			* {{(HL_W-HI_W){b_hi[HI_W-1]}}, b_hi};
		assign ll_d[g] = {{(LL_W-LO_W){1'b0}}, a_lo} * {{(LL_W-LO_W){1'b0}}, b_lo};

		// stage 5: align and add the partial products
		assign prod_d[g] = ({{(PROD_W-HH_W){hh_s4[g][HH_W-1]}}, hh_s4[g]} << (2 * LO_W))
			+ (({{(PROD_W-HL_W){hl_s4[g][HL_W-1]}}, hl_s4[g]}
			+ {{(PROD_W-HL_W){lh_s4[g][HL_W-1]}}, lh_s4[g]}) << LO_W)
			+ {{(PROD_W-LL_W){1'b0}}, ll_s4[g]};
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			hh_s4 <= hh_d;
			hl_s4 <= hl_d;
			lh_s4 <= lh_d;
			ll_s4 <= ll_d;
		end
		if (rdy_s5 && v_s4) prod_s5 <= prod_d;
	end

endmodule

[src/pit_decide.sv]
// stages 6 to 8: determinant and numerators, sign tests, output register
module pit_decide import pit_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [NUM_PROD-1:0][4*COORD_WIDTH+7:0] prod,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   inside_res,
	output logic                                   degenerate
);

	localparam int unsigned PROD_W = 4 * COORD_WIDTH + 8;
	localparam int unsigned RES_W  = PROD_W + 2;

	logic v_s6, v_s7, v_s8;
	logic rdy_s6, rdy_s7, rdy_s8;

	logic [RES_W-1:0] det_d, un_d, vn_d;
	logic [RES_W-1:0] det_s6, un_s6, vn_s6;
	logic [RES_W-1:0] det_s7, sum_s7, slack;
	logic             degen_s7, un_neg_s7, vn_neg_s7;
	logic             inside_s8, degen_s8;

	assign rdy_s8    = !v_s8 || out_ready;
	assign rdy_s7    = !v_s7 || rdy_s8;
	assign rdy_s6    = !v_s6 || rdy_s7;
	assign in_ready  = rdy_s6;
	assign out_valid = v_s8;
	assign inside_res = inside_s8;
	assign degenerate = degen_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_s6) v_s6 <= in_valid;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
		end
	end

	// stage 6: det = d00*d11 - d01^2, un = d11*d02 - d01*d12, vn = d00*d12 - d01*d02
	assign det_d = {{2{prod[PROD_DET_P][PROD_W-1]}}, prod[PROD_DET_P]}
		- {{2{prod[PROD_DET_N][PROD_W-1]}}, prod[PROD_DET_N]};
	assign un_d  = {{2{prod[PROD_UN_P][PROD_W-1]}}, prod[PROD_UN_P]}
		- {{2{prod[PROD_UN_N][PROD_W-1]}}, prod[PROD_UN_N]};
	assign vn_d  = {{2{prod[PROD_VN_P][PROD_W-1]}}, prod[PROD_VN_P]}
		- {{2{prod[PROD_VN_N][PROD_W-1]}}, prod[PROD_VN_N]};

	// stage 8 input: room left under the determinant
	assign slack = det_s7 - sum_s7;

	always_ff @(posedge clk) begin
		if (rdy_s6 && in_valid) begin
			det_s6 <= det_d;
			un_s6  <= un_d;
			vn_s6  <= vn_d;
		end
		// stage 7: zero test, signs and numerator sum
		if (rdy_s7 && v_s6) begin
			degen_s7  <= (det_s6 == '0);
			un_neg_s7 <= un_s6[RES_W-1];
			vn_neg_s7 <= vn_s6[RES_W-1];
			det_s7    <= det_s6;
			sum_s7    <= un_s6 + vn_s6;
		end
		// stage 8: final decision into the output register
		if (rdy_s8 && v_s7) begin
			inside_s8 <= !degen_s7 && !un_neg_s7 && !vn_neg_s7 && !slack[RES_W-1];
			degen_s8  <= degen_s7;
		end
	end

endmodule

[src/point_in_triangle_test.sv]
// top level of the point-in-triangle test: vertex registers, pipeline and stream ports
//
// Usage:
// - load the three vertices through cfg_we / cfg_index / cfg_data (index 0 is vertex a,
//   1 is vertex b, 2 is vertex c; x, y, z packed from the low bits up, each signed);
//   other indexes are ignored; write only while no item is in flight
// - each item on the s_axis side carries one point x, y, z; each yields one item on
//   the m_axis side with inside_res (edges count as inside) and degenerate
// - a degenerate triangle (zero determinant) gives inside_res 0 and degenerate 1
// Timing:
// - eight register stages, s1 to s8, lie between an accepted point and its result on m_axis
// - one item per cycle sustained while m_axis_tready is high; the depth is set by the two
//   levels of products (per-axis products, then the 2x2 determinant forms split into
//   partial products)
// - every stage has its own valid bit and loads when empty or when its successor
//   takes its item, so bubbles close up and a stall on m_axis_tready holds items
//   in place without loss; s_axis_tready drops only once all stages are full
// Reset:
// - arst_n clears all valid bits and sets the vertices to zero (a degenerate triangle)
module point_in_triangle_test import pit_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [CFG_IDX_W-1:0]                 cfg_index,
	input  logic [3*COORD_WIDTH-1:0]             cfg_data,
	// points in
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// point_x, point_y, point_z, zero padding
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	// results out
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// inside_res, degenerate, zero padding
	output logic [OUT_TDATA_W-1:0]               m_axis_tdata
);

	localparam int unsigned DOT_W  = 2 * COORD_WIDTH + 4;
	localparam int unsigned PROD_W = 4 * COORD_WIDTH + 8;

	logic [3*COORD_WIDTH-1:0] vertex_a_q, vertex_b_q, vertex_c_q;

	logic [NUM_AXES-1:0][COORD_WIDTH-1:0] point;
	logic [NUM_DOT-1:0][DOT_W-1:0]        dot;
	logic [NUM_PROD-1:0][PROD_W-1:0]      prod;
	logic dot_valid, dot_ready, prod_valid, prod_ready;
	logic inside_res, degenerate;

	// vertex registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_a_q <= '0;
			vertex_b_q <= '0;
			vertex_c_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VERTEX_A: vertex_a_q <= cfg_data;
				REG_VERTEX_B: vertex_b_q <= cfg_data;
				REG_VERTEX_C: vertex_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack the point item
	for (genvar k = 0; k < NUM_AXES; k++) begin : g_point
		assign point[k] = s_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH];
	end

	pit_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.vertex_a  (vertex_a_q),
		.vertex_b  (vertex_b_q),
		.vertex_c  (vertex_c_q),
		.point     (point),
		.out_valid (dot_valid),
		.out_ready (dot_ready),
		.dot       (dot)
	);

	pit_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dot_valid),
		.in_ready  (dot_ready),
		.dot       (dot),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.prod      (prod)
	);

	pit_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (prod_valid),
		.in_ready   (prod_ready),
		.prod       (prod),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.inside_res (inside_res),
		.degenerate (degenerate)
	);

	// pack the result item
	always_comb begin
		m_axis_tdata                 = '0;
		m_axis_tdata[OUT_BIT_INSIDE] = inside_res;
		m_axis_tdata[OUT_BIT_DEGEN]  = degenerate;
	end

	// a degenerate triangle never reports a point inside
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[OUT_BIT_INSIDE] && m_axis_tdata[OUT_BIT_DEGEN]))
		else $error("inside reported for a degenerate triangle");

	// with the output register empty the ready chain must reach the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while the output register is empty");

endmodule
